/* rtl/core/sbp_pkg.sv */
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared types and constants for the six-bit text word packer.
// ----------------------------------------------------------------------------
`default_nettype none

package sbp_pkg;

  localparam int CODE_W      = 7;
  localparam int SLOT_W      = 6;
  localparam int WORD_W      = 30;
  localparam int MAX_RES     = 3;
  localparam int CNT_W       = 2;
  localparam int IN_TDATA_W  = ((CODE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((WORD_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CODE_W-1:0] BLANK_CODE  = 7'd0;
  localparam logic [CODE_W-1:0] ESCAPE_CODE = 7'd63;
  localparam logic [CODE_W-1:0] FOLD_LOW    = 7'd37;
  localparam logic [CODE_W-1:0] FOLD_OFFSET = 7'd26;
  localparam logic [SLOT_W-1:0] ESCAPE_SLOT = 6'd63;

  localparam logic [CFG_IDX_W-1:0] REG_SKIP_LEADING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_AT_BLANK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD_UPPER    = 2'd2;

  typedef struct packed {
    logic skip_leading_blanks;
    logic stop_at_blank;
    logic fold_upper;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic              has_char;
    logic              line_end;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] packed_word;
    logic              end_marker;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]          count;
    result_t [MAX_RES-1:0]     res;
  } res_set_t;

endpackage

`default_nettype wire

/* rtl/core/six_bit_text_word_packer.sv */
// ----------------------------------------------------------------------------
// six_bit_text_word_packer
// Packs mapped 7-bit character codes into words of 6-bit slots, first
// character in the top slot, with escape pairs for codes of 63 and above.
//
// Input stream: one character per transaction. tdata holds char_code,
// tuser flags has_char, tlast marks the line end. Output stream: one word per
// transaction; tuser set on the end marker, tlast on the final word caused by
// an input transaction. Each input gives zero to three words.
// An accepted item is held in the input register, then the packing step
// writes its words to the result register, from which the first word is
// offered on the output stream.
// One item per cycle is taken while each gives at most one word and the
// receiver is ready; an item with more words holds the input side until
// the single output register has drained.
// Configuration is a plain write port, to be written only while the block is
// idle.
// Synchronous reset clears the config, the slot state and both streams' valid flags.
// A stalled receiver holds the current word; the input register then fills
// and tready drops until the result register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module six_bit_text_word_packer
  import sbp_pkg::*;
#(
  parameter int SLOTS_PER_WORD = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [6:0] char_code
  input  logic                   in_tuser,   // has_char
  input  logic                   in_tlast,   // line_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [29:0] packed_word
  output logic                   out_tuser,  // end_marker
  output logic                   out_tlast,  // last
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic                   cfg_wdata
);

  localparam int ACC_W  = SLOT_W * SLOTS_PER_WORD;
  localparam int FILL_W = $clog2(SLOTS_PER_WORD + 1);

  cfg_t              cfg_r;
  item_t             item_r;
  logic              in_valid_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              fin_r, fin_nxt;
  res_set_t          set;
  logic              can_load;
  logic              step_go;
  logic [WORD_W-1:0] word;

  assign step_go   = in_valid_r && can_load;
  assign in_tready = !in_valid_r || step_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SKIP_LEADING:  cfg_r.skip_leading_blanks <= cfg_wdata;
        REG_STOP_AT_BLANK: cfg_r.stop_at_blank       <= cfg_wdata;
        REG_FOLD_UPPER:    cfg_r.fold_upper          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.char_code <= in_tdata[CODE_W-1:0];
      item_r.has_char  <= in_tuser;
      item_r.line_end  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      fill_r <= '0;
      fin_r  <= 1'b0;
    end else if (step_go) begin
      acc_r  <= acc_nxt;
      fill_r <= fill_nxt;
      fin_r  <= fin_nxt;
    end
  end

  sbp_step #(
    .SLOTS (SLOTS_PER_WORD)
  ) u_step (
    .cfg    (cfg_r),
    .item   (item_r),
    .acc_i  (acc_r),
    .fill_i (fill_r),
    .fin_i  (fin_r),
    .acc_o  (acc_nxt),
    .fill_o (fill_nxt),
    .fin_o  (fin_nxt),
    .set_o  (set)
  );

  sbp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_go),
    .set_i      (set),
    .can_load   (can_load),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_word   (word),
    .out_marker (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = OUT_TDATA_W'(word);

endmodule

`default_nettype wire

/* rtl/core/sbp_step.sv */
// ----------------------------------------------------------------------------
// sbp_step
// Combinational packing step: one character against the slot state, giving
// the next state and up to three result words.
// ----------------------------------------------------------------------------
`default_nettype none

module sbp_step
  import sbp_pkg::*;
#(
  parameter int SLOTS = 5,
  localparam int ACC_W  = SLOT_W * SLOTS,
  localparam int FILL_W = $clog2(SLOTS + 1)
) (
  input  cfg_t              cfg,
  input  item_t             item,
  input  logic [ACC_W-1:0]  acc_i,
  input  logic [FILL_W-1:0] fill_i,
  input  logic              fin_i,
  output logic [ACC_W-1:0]  acc_o,
  output logic [FILL_W-1:0] fill_o,
  output logic              fin_o,
  output res_set_t          set_o
);

  localparam int SH_W = $clog2(ACC_W + 1);
  localparam logic [FILL_W-1:0] LAST_SLOT = FILL_W'(SLOTS - 1);

  function automatic logic [WORD_W-1:0] pad_word(input logic [ACC_W-1:0] a,
                                                 input logic [FILL_W-1:0] f);
    logic [FILL_W-1:0] pad;
    logic [SH_W-1:0]   sh;
    pad = FILL_W'(SLOTS) - f;
    sh  = SH_W'(pad) * SH_W'(SLOT_W);
    return WORD_W'(a << sh);
  endfunction

  always_comb begin
    logic [ACC_W-1:0]  a;
    logic [FILL_W-1:0] f;
    logic              wf;
    logic [CNT_W-1:0]  n;
    logic [SLOT_W-1:0] v;
    logic              full;
    logic              esc;
    logic              blank;
    a     = acc_i;
    f     = fill_i;
    wf    = fin_i;
    n     = '0;
    v     = '0;
    full  = 1'b0;
    set_o = '0;
    esc   = item.char_code >= ESCAPE_CODE;
    blank = item.char_code == BLANK_CODE;

    if (item.has_char && !wf) begin
      if (!(cfg.skip_leading_blanks && blank && f == '0)) begin
        if (cfg.stop_at_blank && blank) begin
          set_o.res[n].packed_word = pad_word(a, f);
          set_o.res[n].end_marker  = 1'b0;
          n  = n + 1'b1;
          a  = '0;
          f  = '0;
          wf = 1'b1;
        end else begin
          if (esc) begin
            v = ESCAPE_SLOT;
          end else if (cfg.fold_upper && item.char_code >= FOLD_LOW) begin
            v = SLOT_W'(item.char_code - FOLD_OFFSET);
          end else begin
            v = SLOT_W'(item.char_code);
          end
          full = f == LAST_SLOT;
          a    = (a << SLOT_W) | ACC_W'(v);
          if (full) begin
            set_o.res[n].packed_word = WORD_W'(a);
            set_o.res[n].end_marker  = 1'b0;
            n = n + 1'b1;
            a = '0;
            f = '0;
          end else begin
            f = f + 1'b1;
          end
          if (full && cfg.stop_at_blank) begin
            wf = 1'b1;
          end else if (esc) begin
            // second half of the escape pair, modulo one slot
            v    = SLOT_W'(item.char_code - ESCAPE_CODE);
            full = f == LAST_SLOT;
            a    = (a << SLOT_W) | ACC_W'(v);
            if (full) begin
              set_o.res[n].packed_word = WORD_W'(a);
              set_o.res[n].end_marker  = 1'b0;
              n = n + 1'b1;
              a = '0;
              f = '0;
              if (cfg.stop_at_blank) begin
                wf = 1'b1;
              end
            end else begin
              f = f + 1'b1;
            end
          end
        end
      end
    end

    if (item.line_end) begin
      if (!cfg.stop_at_blank || !wf) begin
        if (f != '0) begin
          set_o.res[n].packed_word = pad_word(a, f);
          set_o.res[n].end_marker  = 1'b0;
          n = n + 1'b1;
        end
        if (!cfg.stop_at_blank || f == '0) begin
          set_o.res[n].packed_word = '0;
          set_o.res[n].end_marker  = 1'b1;
          n = n + 1'b1;
        end
      end
      a  = '0;
      f  = '0;
      wf = 1'b0;
    end

    set_o.count = n;
    acc_o       = a;
    fill_o      = f;
    fin_o       = wf;
  end

endmodule

`default_nettype wire

/* rtl/core/sbp_out_buf.sv */
// ----------------------------------------------------------------------------
// sbp_out_buf
// Result register: holds the words of one step and hands them out one
// transaction at a time, flagging the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module sbp_out_buf
  import sbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  res_set_t          set_i,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_word,
  output logic              out_marker,
  output logic              out_last
);

  result_t [MAX_RES-1:0] res_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      idx_r;
  logic                  take;

  assign out_valid  = cnt_r != '0;
  assign out_last   = idx_r == (cnt_r - 1'b1);
  assign out_word   = res_r[idx_r].packed_word;
  assign out_marker = res_r[idx_r].end_marker;
  assign take       = out_valid && out_ready;
  assign can_load   = !out_valid || (take && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= set_i.count;
      idx_r <= '0;
    end else if (take) begin
      if (out_last) begin
        cnt_r <= '0;
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= set_i.res;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> idx_r < cnt_r)
    else $error("result index beyond stored count");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RES))
    else $error("result count above maximum");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (take && out_last && !load) |=> !out_valid)
    else $error("buffer not empty after final result");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !load)
    else $error("results overwritten while stalled");

endmodule

`default_nettype wire
